// File: design/level_crossing_frequency_meter_core_macros.svh
// Assertion macros for the level-crossing frequency meter checker.
// Depends on nothing; included by the checker file.
`ifndef LEVEL_CROSSING_FREQUENCY_METER_CORE_MACROS_SVH
`define LEVEL_CROSSING_FREQUENCY_METER_CORE_MACROS_SVH

// Same-cycle implication.
`define LCFM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define LCFM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/lcfm_pkg.sv
// Types and constants shared by the level-crossing frequency meter.
// Depends on nothing.
package lcfm_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_FINISH,
      ST_DIV_AVG,
      ST_DIV_FREQ,
      ST_EMIT
   } lcfm_state_type;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_CROSSING_LEVEL   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FULL_SCALE       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SAMPLE_PERIOD_US = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PEAK_LEVEL       = 2'd3;

   localparam logic [7:0]  RST_CROSSING_LEVEL   = 8'd50;
   localparam logic [7:0]  RST_FULL_SCALE       = 8'd250;
   localparam logic [15:0] RST_SAMPLE_PERIOD_US = 16'd112;
   localparam logic [7:0]  RST_PEAK_LEVEL       = 8'd45;
   localparam logic [7:0]  RST_PREVIOUS_SCALED  = 8'd255;

   localparam int          ADC_W     = 10;
   localparam int          LEVEL_W   = 8;
   localparam int          PERIOD_W  = 16;
   localparam int          FREQ_W    = 20;
   localparam int          PAIRS_W   = 10;
   localparam logic [10:0] ADC_FULL  = 11'd1023;
   localparam int          FREQ_NUM  = 1000000;

endpackage

// File: design/lcfm_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing outside this file.
module lcfm_divider #(
   parameter int W = 27
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient
);

   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    shifted;
   logic [W:0]    diff;
   logic          ge;

   assign shifted = {rem_ff, quo_ff[W-1]};
   assign ge      = shifted >= {1'b0, den_ff};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[W-1:0] : shifted[W-1:0];
         quo_in = {quo_ff[W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: design/level_crossing_frequency_meter_core.sv
// Level-crossing frequency meter: per-sample scaling and crossing timing, then two
// iterative divides at window end. Depends on lcfm_pkg and lcfm_divider. Each sample
// is registered in ST_IDLE, then scaled and timed in ST_SCALE; no new sample is taken
// before that is done. At window end the shared divider finds the average period, then
// the frequency; both are skipped when no period is found. DIV_W is 27 by default,
// max(clog2(MAX_WINDOW+1)+16, 20). Synchronous reset restores register defaults.
module level_crossing_frequency_meter_core #(
   parameter int MAX_WINDOW = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: [9:0] adc_sample, rest zero
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,
   input  logic                                req_tlast,
   // rsp_tdata: [19:0] frequency_hz, [29:20] period_pairs, rest zero
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [31:0]                         rsp_tdata,
   // rsp_tuser: [0] peak_seen
   output logic                                rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lcfm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lcfm_pkg::CSR_DATA_W-1:0]     csr_data
);

   import lcfm_pkg::*;

   localparam int TW    = $clog2(MAX_WINDOW + 1);
   localparam int PW    = $clog2(MAX_WINDOW / 2 + 1);
   localparam int DIV_W = (TW + PERIOD_W > FREQ_W) ? TW + PERIOD_W : FREQ_W;

   lcfm_state_type state_ff, state_in;

   logic [LEVEL_W-1:0]  crossing_level_ff, full_scale_ff, peak_level_ff;
   logic [PERIOD_W-1:0] sample_period_ff;

   logic [ADC_W-1:0]    raw_ff, raw_in;
   logic                last_ff, last_in;

   logic                phase_ff, phase_in;
   logic [LEVEL_W-1:0]  prev_ff, prev_in;
   logic [TW-1:0]       period_cnt_ff, period_cnt_in;
   logic [TW-1:0]       total_ff, total_in;
   logic [PW-1:0]       pairs_ff, pairs_in;
   logic                peak_ff, peak_in;
   logic [TW-1:0]       fill_ff, fill_in;

   logic [FREQ_W-1:0]   freq_ff, freq_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [31:0]         rsp_data_ff, rsp_data_in;
   logic                rsp_user_ff, rsp_user_in;

   logic [17:0]         product;
   logic [LEVEL_W-1:0]  q_est;
   logic [10:0]         q_rem;
   logic [LEVEL_W-1:0]  scaled;
   logic                crossing;
   logic [TW-1:0]       period_next;
   logic [PW+PAIRS_W-1:0] pairs_ext;

   logic                div_start;
   logic [DIV_W-1:0]    div_dividend, div_divisor, div_quotient;
   logic                div_done;

   lcfm_divider #(.W(DIV_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign product     = 18'(raw_ff) * 18'(full_scale_ff);
   assign q_est       = product[17:10];
   assign q_rem       = {1'b0, product[9:0]} + 11'(q_est);
   assign scaled      = (q_rem >= ADC_FULL) ? q_est + 1'b1 : q_est;
   assign crossing    = (prev_ff <= crossing_level_ff) && (scaled > crossing_level_ff);
   assign period_next = period_cnt_ff + 1'b1;
   assign pairs_ext   = {{PAIRS_W{1'b0}}, pairs_ff};

   always_comb begin
      state_in      = state_ff;
      raw_in        = raw_ff;
      last_in       = last_ff;
      phase_in      = phase_ff;
      prev_in       = prev_ff;
      period_cnt_in = period_cnt_ff;
      total_in      = total_ff;
      pairs_in      = pairs_ff;
      peak_in       = peak_ff;
      fill_in       = fill_ff;
      freq_in       = freq_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      div_start     = 1'b0;
      div_dividend  = DIV_W'(total_ff) * DIV_W'(sample_period_ff);
      div_divisor   = DIV_W'(pairs_ff);

      if (rsp_valid_ff && rsp_tready)
         rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               raw_in   = req_tdata[ADC_W-1:0];
               last_in  = req_tlast;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (fill_ff < TW'(MAX_WINDOW)) begin
               fill_in = fill_ff + 1'b1;
               prev_in = scaled;
               if (scaled >= peak_level_ff)
                  peak_in = 1'b1;
               if (!phase_ff) begin
                  if (crossing) begin
                     phase_in      = 1'b1;
                     period_cnt_in = '0;
                  end
               end else begin
                  period_cnt_in = period_next;
                  if (crossing) begin
                     total_in      = total_ff + period_next;
                     pairs_in      = pairs_ff + 1'b1;
                     phase_in      = 1'b0;
                     period_cnt_in = '0;
                  end
               end
            end
            state_in = last_ff ? ST_FINISH : ST_IDLE;
         end
         ST_FINISH: begin
            if (total_ff == '0 || sample_period_ff == '0 || pairs_ff == '0) begin
               freq_in  = '0;
               state_in = ST_EMIT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV_AVG;
            end
         end
         ST_DIV_AVG: begin
            if (div_done) begin
               if (div_quotient == '0) begin
                  freq_in  = '0;
                  state_in = ST_EMIT;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = DIV_W'(FREQ_NUM);
                  div_divisor  = div_quotient;
                  state_in     = ST_DIV_FREQ;
               end
            end
         end
         ST_DIV_FREQ: begin
            if (div_done) begin
               freq_in  = div_quotient[FREQ_W-1:0];
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = {2'b00, pairs_ext[PAIRS_W-1:0], freq_ff};
               rsp_user_in   = peak_ff;
               phase_in      = 1'b0;
               prev_in       = RST_PREVIOUS_SCALED;
               period_cnt_in = '0;
               total_in      = '0;
               pairs_in      = '0;
               peak_in       = 1'b0;
               fill_in       = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= 1'b0;
         prev_ff       <= RST_PREVIOUS_SCALED;
         period_cnt_ff <= '0;
         total_ff      <= '0;
         pairs_ff      <= '0;
         peak_ff       <= 1'b0;
         fill_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         prev_ff       <= prev_in;
         period_cnt_ff <= period_cnt_in;
         total_ff      <= total_in;
         pairs_ff      <= pairs_in;
         peak_ff       <= peak_in;
         fill_ff       <= fill_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff      <= raw_in;
      last_ff     <= last_in;
      freq_ff     <= freq_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crossing_level_ff <= RST_CROSSING_LEVEL;
         full_scale_ff     <= RST_FULL_SCALE;
         sample_period_ff  <= RST_SAMPLE_PERIOD_US;
         peak_level_ff     <= RST_PEAK_LEVEL;
      end else if (csr_valid) begin
         case (csr_index)
            REG_CROSSING_LEVEL:   crossing_level_ff <= csr_data[LEVEL_W-1:0];
            REG_FULL_SCALE:       full_scale_ff     <= csr_data[LEVEL_W-1:0];
            REG_SAMPLE_PERIOD_US: sample_period_ff  <= csr_data[PERIOD_W-1:0];
            REG_PEAK_LEVEL:       peak_level_ff     <= csr_data[LEVEL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// File: design/lcfm_checker.sv
// Port-level checks for the level-crossing frequency meter, bound to the top level.
// Depends on level_crossing_frequency_meter_core_macros.svh.
`include "level_crossing_frequency_meter_core_macros.svh"

module lcfm_port_props (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             req_tlast,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [31:0]                      rsp_tdata,
   input logic                             rsp_tuser
);

   `LCFM_ASSERT_NEXT(a_busy_after_sample, clock, reset, req_tvalid && req_tready,
      !req_tready, "sample taken while previous one in progress")

   `LCFM_ASSERT_NEXT(a_ready_after_plain_sample, clock, reset,
      req_tvalid && req_tready && !req_tlast, ##1 req_tready,
      "not ready two cycles after a non-final sample")

   `LCFM_ASSERT_NOW(a_freq_in_range, clock, reset, rsp_tvalid,
      rsp_tdata[19:0] <= 20'd1000000, "frequency beyond one megahertz")

   `LCFM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

endmodule

bind level_crossing_frequency_meter_core lcfm_port_props u_lcfm_checker (.*);
